// ----- rtl/core/mfq_pkg.sv -----
// Shared types and constants of the multilevel feedback queue order block.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
package mfq_pkg;

  localparam int BURST_W   = 16;
  localparam int QUANTUM_W = 16;
  localparam int JOB_NUM_W = 5;
  localparam int LVL_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUANTUM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_QUANTUM = 1'd1;

  localparam logic [QUANTUM_W-1:0] FIRST_QUANTUM_RST  = 16'd4;
  localparam logic [QUANTUM_W-1:0] SECOND_QUANTUM_RST = 16'd8;

  // Finish levels.
  localparam logic [LVL_W-1:0] LVL_RR0  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_RR1  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_FCFS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted request
    logic scan_init;   // rewind the scan to level 0, entry 0
    logic scan_step;   // issue one store read and advance the scan
    logic batch_clear; // empty the store for the next batch
  } mfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the read being issued is the final one of the flush
  } mfq_sts_t;

endpackage

// ----- rtl/core/multilevel_feedback_queue_order.sv -----
// Top level of the multilevel feedback queue order block.
// Depends on mfq_pkg, mfq_ctrl and mfq_dp.
//
// Each request carries the burst time of one job and is taken in a single
// cycle whenever busy is low, so a batch loads at one job per cycle. A job is
// classified as it arrives: level 0 if its burst is at most the first
// quantum, level 1 if it is at most the sum of both quanta, level 2
// otherwise. The request marked last_job starts the flush: busy rises and the
// level store is scanned three times, once per level, one entry per cycle
// through its single registered read port, so the block stays busy through
// the three passes and the drain state after the last request. A batch holds
// at most MAX_JOBS jobs; requests beyond that are dropped, though a dropped
// last request still flushes. Results appear on out_valid for one cycle
// each in completion order, with gaps where a scanned entry belongs to
// another level; the final one, flagged by out_last_result, appears no later
// than the cycle after busy falls, and in exactly that cycle when the last
// job of the batch finishes in the first come first served level. The
// receiver cannot stall results, so it must take each one as it is shown.
// The quanta may only be rewritten while the block is idle and no results
// are pending.
module multilevel_feedback_queue_order
  import mfq_pkg::*;
#(
  parameter int MAX_JOBS = 16
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 start,
  output logic                 busy,
  input  logic [BURST_W-1:0]   in_burst_time,
  input  logic                 in_last_job,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUANTUM_W-1:0] cfg_wdata,
  // Result channel.
  output logic                 out_valid,
  output logic [JOB_NUM_W-1:0] out_job_number,
  output logic [LVL_W-1:0]     out_finish_level,
  output logic                 out_last_result
);

  mfq_cmd_t cmd;
  mfq_sts_t sts;

  // The controller sequences loading and the three-pass flush.
  mfq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_job (in_last_job),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // The datapath holds the quanta, the level store and the result register.
  mfq_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_burst_time    (in_burst_time),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_job_number   (out_job_number),
    .out_finish_level (out_finish_level),
    .out_last_result  (out_last_result)
  );

endmodule

// ----- rtl/core/mfq_ctrl.sv -----
// Controller state machine of the multilevel feedback queue order block.
// Depends on mfq_pkg for the command and status structs.
module mfq_ctrl
  import mfq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last_job,
  input  mfq_sts_t sts,
  output mfq_cmd_t cmd,
  output logic     busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt       = state_r;
    cmd.load        = 1'b0;
    cmd.scan_init   = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.batch_clear = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load      = accept;
        cmd.scan_init = accept && in_last_job;
        if (accept && in_last_job) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The final read is compared in this cycle; the batch is then dropped.
        cmd.batch_clear = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/mfq_dp.sv -----
// Datapath of the multilevel feedback queue order block: quanta, classifier,
// level store, scan counters and result register. Depends on mfq_pkg.
module mfq_dp
  import mfq_pkg::*;
#(
  parameter int MAX_JOBS = 16
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfq_cmd_t             cmd,
  output mfq_sts_t             sts,
  input  logic [BURST_W-1:0]   in_burst_time,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUANTUM_W-1:0] cfg_wdata,
  output logic                 out_valid,
  output logic [JOB_NUM_W-1:0] out_job_number,
  output logic [LVL_W-1:0]     out_finish_level,
  output logic                 out_last_result
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int NUM_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

  logic [QUANTUM_W-1:0] first_quantum_r;
  logic [QUANTUM_W-1:0] second_quantum_r;

  logic [LVL_W-1:0]     store_mem [MAX_JOBS];
  logic [LVL_W-1:0]     mem_q_r;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     emit_cnt_r;
  logic [CNT_W-1:0]     count_m1;
  logic [IDX_W-1:0]     idx_r;
  logic [LVL_W-1:0]     lvl_r;
  logic                 idx_end;

  logic                 p_valid_r;
  logic [IDX_W-1:0]     p_idx_r;
  logic [LVL_W-1:0]     p_lvl_r;
  logic                 match;
  logic [NUM_W-1:0]     job_num;

  logic [QUANTUM_W:0]   limit2;
  logic [LVL_W-1:0]     new_lvl;
  logic                 has_room;

  logic                 out_valid_r;
  logic [JOB_NUM_W-1:0] out_job_number_r;
  logic [LVL_W-1:0]     out_finish_level_r;
  logic                 out_last_result_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_quantum_r  <= FIRST_QUANTUM_RST;
      second_quantum_r <= SECOND_QUANTUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_QUANTUM:  first_quantum_r  <= cfg_wdata;
        CFG_SECOND_QUANTUM: second_quantum_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classification of the arriving job; the quantum sum is kept at 17 bits.
  assign limit2 = {1'b0, first_quantum_r} + {1'b0, second_quantum_r};

  always_comb begin
    if (in_burst_time <= first_quantum_r) begin
      new_lvl = LVL_RR0;
    end else if ({1'b0, in_burst_time} <= limit2) begin
      new_lvl = LVL_RR1;
    end else begin
      new_lvl = LVL_FCFS;
    end
  end

  assign has_room = (count_r < CNT_MAX);

  // Level store: one write port at the fill position, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      store_mem[count_r[IDX_W-1:0]] <= new_lvl;
    end
    mem_q_r <= store_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.batch_clear) begin
      count_r <= '0;
    end else if (cmd.load && has_room) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Scan position: entry index within the current level.
  assign count_m1      = count_r - 1'b1;
  assign idx_end       = ({{(CNT_W - IDX_W){1'b0}}, idx_r} == count_m1);
  assign sts.scan_last = (count_r == '0) || (idx_end && (lvl_r == LVL_FCFS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      lvl_r <= LVL_RR0;
    end else if (cmd.scan_init) begin
      idx_r <= '0;
      lvl_r <= LVL_RR0;
    end else if (cmd.scan_step) begin
      if (idx_end) begin
        idx_r <= '0;
        lvl_r <= lvl_r + 1'b1;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Read pipeline: tags travel alongside the registered store output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.scan_step && (count_r != '0);
    end
    p_idx_r <= idx_r;
    p_lvl_r <= lvl_r;
  end

  assign match   = p_valid_r && (mem_q_r == p_lvl_r);
  assign job_num = {1'b0, p_idx_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= '0;
    end else if (cmd.scan_init) begin
      emit_cnt_r <= '0;
    end else if (match) begin
      emit_cnt_r <= emit_cnt_r + 1'b1;
    end
  end

  // Result register; every stored job is emitted once, so the final result
  // is the one that brings the emitted count up to the stored count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= match;
    end
    out_job_number_r   <= JOB_NUM_W'(job_num);
    out_finish_level_r <= p_lvl_r;
    out_last_result_r  <= (emit_cnt_r == count_m1);
  end

  assign out_valid        = out_valid_r;
  assign out_job_number   = out_job_number_r;
  assign out_finish_level = out_finish_level_r;
  assign out_last_result  = out_last_result_r;

endmodule

// ----- rtl/core/mfq_checker.sv -----
// Port-level checker for the multilevel feedback queue order block, bound to
// the top level. Depends on mfq_pkg for field widths.
module mfq_checker
  import mfq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_last_job,
  input logic                 out_valid,
  input logic [LVL_W-1:0]     out_finish_level,
  input logic                 out_last_result
);

  // A flush begins only after a request marked last is taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_last_job))
    else $error("busy rose without a last request");

  // Results appear only during a flush or in the cycle that closes it.
  a_out_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || $past(busy)))
    else $error("result outside a flush");

  // Any result other than the final one is shown while still busy.
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> busy)
    else $error("non-final result after the flush ended");

  // The final result ends the batch.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=> !out_valid)
    else $error("result after the final result");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finish_level == LVL_RR0 || out_finish_level == LVL_RR1 ||
                   out_finish_level == LVL_FCFS))
    else $error("illegal finish level");

endmodule

bind multilevel_feedback_queue_order mfq_checker u_mfq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last_job      (in_last_job),
  .out_valid        (out_valid),
  .out_finish_level (out_finish_level),
  .out_last_result  (out_last_result)
);
